[rtl/core/uas_pkg.sv]
// Package for the undirected adjacency store: sizes, item structs, action and status codes.
// No dependencies.
package uas_pkg;
	localparam int VERTEX_COUNT = 256;
	localparam int MAX_DEGREE   = 16;
	localparam int VW = 8;
	localparam int DW = $clog2(MAX_DEGREE);
	localparam int CW = $clog2(MAX_DEGREE + 1);
	localparam int AW = VW + DW;

	localparam logic [1:0] ACT_ADD_EDGE = 2'd0;
	localparam logic [1:0] ACT_DEL_EDGE = 2'd1;
	localparam logic [1:0] ACT_ADD_MARK = 2'd2;
	localparam logic [1:0] ACT_DEL_MARK = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]    action;
		logic [VW-1:0] src_vertex;
		logic [VW-1:0] dest_vertex;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       edge_was_present;
		logic       mark_was_present;
		logic [4:0] src_degree;
		logic [4:0] src_mark_count;
	} rsp_t;
endpackage

[rtl/core/uas_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module uas_ram #(
	parameter int AWID = 12,
	parameter int DWID = 8
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AWID-1:0] addr,
	input  logic [DWID-1:0] wdata,
	output logic [DWID-1:0] rdata
);
	logic [DWID-1:0] mem [2**AWID];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/core/undirected_adjacency_store_unit.sv]
// Undirected adjacency store: per-vertex neighbour and mark lists walked by one sequencer.
// List entries are walked one at a time through a shared compare.
// Each item takes two list searches, and removals take a third.
// One item at a time; in_stall stays high from acceptance until the result is taken.
// Reset starts a pass over all 256 vertices that clears the degree and mark counts; in_stall holds high.
// Depends on uas_pkg and uas_ram.
module undirected_adjacency_store_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  uas_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output uas_pkg::rsp_t out_data
);
	localparam int VW = uas_pkg::VW;
	localparam int DW = uas_pkg::DW;
	localparam int CW = uas_pkg::CW;
	localparam int AW = uas_pkg::AW;
	localparam logic [CW-1:0] MAXD = CW'(uas_pkg::MAX_DEGREE);
	localparam logic [VW-1:0] LAST_VTX = VW'(uas_pkg::VERTEX_COUNT - 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CNT0 = 4'd2;
	localparam logic [3:0] S_CNT1 = 4'd3;
	localparam logic [3:0] S_CNT2 = 4'd4;
	localparam logic [3:0] S_SRCH = 4'd5;
	localparam logic [3:0] S_WAIT = 4'd6;
	localparam logic [3:0] S_DEC  = 4'd7;
	localparam logic [3:0] S_RM   = 4'd8;
	localparam logic [3:0] S_RMW  = 4'd9;
	localparam logic [3:0] S_WR   = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0] state_q;
	uas_pkg::req_t req_q;
	logic [VW-1:0] clr_q;
	logic [CW-1:0] ns_q, nd_q, ms_q, md_q;
	logic [CW-1:0] idx_q;
	logic [DW-1:0] ehit_q, mhit_q, hit_q;
	logic edge_q, mark_q, side_q, ismark_q;
	logic [1:0] status_q;
	logic [VW-1:0] last_q;

	logic          n_we, m_we, nc_we, mc_we;
	logic [AW-1:0] addr;
	logic [VW-1:0] wdata, n_rd, m_rd, rd;
	logic [VW-1:0] caddr;
	logic [CW-1:0] cwdata, nc_rd, mc_rd;

	uas_ram #(.AWID(AW), .DWID(VW)) u_nram (
		.clk(clk), .we(n_we), .addr(addr), .wdata(wdata), .rdata(n_rd));
	uas_ram #(.AWID(AW), .DWID(VW)) u_mram (
		.clk(clk), .we(m_we), .addr(addr), .wdata(wdata), .rdata(m_rd));
	uas_ram #(.AWID(VW), .DWID(CW)) u_ncnt (
		.clk(clk), .we(nc_we), .addr(caddr), .wdata(cwdata), .rdata(nc_rd));
	uas_ram #(.AWID(VW), .DWID(CW)) u_mcnt (
		.clk(clk), .we(mc_we), .addr(caddr), .wdata(cwdata), .rdata(mc_rd));

	logic [VW-1:0] own, other;
	logic [CW-1:0] cnt_own, cnt_new;
	logic          del;
	logic          distinct;
	logic          rd_match;
	logic          sdone, sfound;
	logic [3:0]    srch_next;
	logic [1:0]    dec_status;
	logic [3:0]    dec_next;

	always_comb begin
		own   = side_q ? req_q.dest_vertex : req_q.src_vertex;
		other = side_q ? req_q.src_vertex : req_q.dest_vertex;
		case ({ismark_q, side_q})
			2'b00:   cnt_own = ns_q;
			2'b01:   cnt_own = nd_q;
			2'b10:   cnt_own = ms_q;
			default: cnt_own = md_q;
		endcase
		del      = req_q.action[0];
		cnt_new  = del ? cnt_own - CW'(1) : cnt_own + CW'(1);
		distinct = req_q.src_vertex != req_q.dest_vertex;
		rd       = ismark_q ? m_rd : n_rd;
		rd_match = rd == other;
		addr     = {own, idx_q[DW-1:0]};
		wdata    = other;
		caddr    = own;
		cwdata   = cnt_new;
		n_we     = 1'b0;
		m_we     = 1'b0;
		nc_we    = 1'b0;
		mc_we    = 1'b0;
		case (state_q)
			S_CLR: begin
				caddr  = clr_q;
				cwdata = '0;
				nc_we  = 1'b1;
				mc_we  = 1'b1;
			end
			S_CNT0: caddr = req_q.src_vertex;
			S_CNT1: caddr = req_q.dest_vertex;
			S_RM: addr = {own, DW'(cnt_own - CW'(1))};
			S_WR: begin
				addr  = {own, del ? hit_q : cnt_own[DW-1:0]};
				wdata = del ? last_q : other;
				n_we  = !ismark_q;
				m_we  = ismark_q;
				nc_we = !ismark_q;
				mc_we = ismark_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sdone  = (state_q == S_SRCH && idx_q >= cnt_own) || (state_q == S_WAIT && rd_match);
		sfound = state_q == S_WAIT;
		if (side_q) begin
			srch_next = sfound ? S_RM : S_OUT;
		end else if (ismark_q) begin
			srch_next = S_DEC;
		end else begin
			srch_next = S_SRCH;
		end
	end

	always_comb begin
		dec_status = uas_pkg::ST_REJECT;
		dec_next   = S_OUT;
		case (req_q.action)
			uas_pkg::ACT_ADD_EDGE: if (!edge_q && distinct) begin
				if (ns_q >= MAXD || nd_q >= MAXD) begin
					dec_status = uas_pkg::ST_FULL;
				end else begin
					dec_status = uas_pkg::ST_DONE;
					dec_next   = S_WR;
				end
			end
			uas_pkg::ACT_DEL_EDGE: if (edge_q && distinct) begin
				dec_status = uas_pkg::ST_DONE;
				dec_next   = S_RM;
			end
			uas_pkg::ACT_ADD_MARK: if (!mark_q && edge_q && distinct) begin
				if (ms_q >= MAXD || md_q >= MAXD) begin
					dec_status = uas_pkg::ST_FULL;
				end else begin
					dec_status = uas_pkg::ST_DONE;
					dec_next   = S_WR;
				end
			end
			default: if (mark_q && distinct) begin
				dec_status = uas_pkg::ST_DONE;
				dec_next   = S_RM;
			end
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		out_data.status           = status_q;
		out_data.edge_was_present = edge_q;
		out_data.mark_was_present = mark_q;
		out_data.src_degree       = ns_q;
		out_data.src_mark_count   = ms_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			req_q    <= '0;
			clr_q    <= '0;
			ns_q     <= '0;
			nd_q     <= '0;
			ms_q     <= '0;
			md_q     <= '0;
			idx_q    <= '0;
			ehit_q   <= '0;
			mhit_q   <= '0;
			hit_q    <= '0;
			edge_q   <= 1'b0;
			mark_q   <= 1'b0;
			side_q   <= 1'b0;
			ismark_q <= 1'b0;
			status_q <= uas_pkg::ST_REJECT;
			last_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + VW'(1);
					if (clr_q == LAST_VTX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: if (in_valid) begin
					req_q   <= in_data;
					state_q <= S_CNT0;
				end
				S_CNT0: state_q <= S_CNT1;
				S_CNT1: begin
					ns_q    <= nc_rd;
					ms_q    <= mc_rd;
					state_q <= S_CNT2;
				end
				S_CNT2: begin
					nd_q     <= nc_rd;
					md_q     <= mc_rd;
					idx_q    <= '0;
					side_q   <= 1'b0;
					ismark_q <= 1'b0;
					state_q  <= S_SRCH;
				end
				S_SRCH, S_WAIT: begin
					if (sdone) begin
						state_q <= srch_next;
						idx_q   <= '0;
						if (!side_q && !ismark_q) begin
							edge_q   <= sfound;
							ehit_q   <= idx_q[DW-1:0];
							ismark_q <= 1'b1;
						end else if (!side_q) begin
							mark_q <= sfound;
							mhit_q <= idx_q[DW-1:0];
						end else begin
							hit_q <= idx_q[DW-1:0];
						end
					end else if (state_q == S_WAIT) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SRCH;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_DEC: begin
					ismark_q <= req_q.action[1];
					hit_q    <= req_q.action[1] ? mhit_q : ehit_q;
					status_q <= dec_status;
					state_q  <= dec_next;
				end
				S_RM: state_q <= S_RMW;
				S_RMW: begin
					last_q  <= rd;
					state_q <= S_WR;
				end
				S_WR: begin
					if (!side_q && !ismark_q) begin
						ns_q <= cnt_new;
					end
					if (!side_q && ismark_q) begin
						ms_q <= cnt_new;
					end
					side_q <= 1'b1;
					idx_q  <= '0;
					if (side_q) begin
						state_q <= S_OUT;
					end else if (del) begin
						state_q <= S_SRCH;
					end else begin
						state_q <= S_WR;
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sim/tb.sv]
// Testbench for undirected_adjacency_store_unit: directed and random add/remove edge and mark items.
// Checks each result against a behavioral adjacency store kept in the bench.
// Depends on uas_pkg and the RTL of the unit.
module tb;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	uas_pkg::req_t in_data;
	logic out_valid;
	logic out_stall;
	uas_pkg::rsp_t out_data;

	logic [7:0] nbr_list [uas_pkg::VERTEX_COUNT][uas_pkg::MAX_DEGREE];
	int nbr_cnt [uas_pkg::VERTEX_COUNT];
	logic [7:0] mark_list [uas_pkg::VERTEX_COUNT][uas_pkg::MAX_DEGREE];
	int mark_cnt [uas_pkg::VERTEX_COUNT];

	uas_pkg::rsp_t pending_rsp [$];
	int errors;
	int cycles;
	bit idle_in;
	bit idle_out;
	bit hold_out;

	undirected_adjacency_store_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit list_holds(input bit mk, input int v, input int val);
		int cnt;
		cnt = mk ? mark_cnt[v] : nbr_cnt[v];
		for (int i = 0; i < cnt; i++) begin
			if (mk && int'(mark_list[v][i]) == val)
				return 1'b1;
			if (!mk && int'(nbr_list[v][i]) == val)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void list_append(input bit mk, input int v, input int val);
		if (mk) begin
			mark_list[v][mark_cnt[v]] = 8'(val);
			mark_cnt[v]++;
		end else begin
			nbr_list[v][nbr_cnt[v]] = 8'(val);
			nbr_cnt[v]++;
		end
	endfunction

	function automatic void drop_entry(input bit mk, input int v, input int val);
		int cnt;
		cnt = mk ? mark_cnt[v] : nbr_cnt[v];
		for (int i = 0; i < cnt; i++) begin
			if (mk && int'(mark_list[v][i]) == val) begin
				mark_list[v][i] = mark_list[v][cnt - 1];
				mark_cnt[v] = cnt - 1;
				return;
			end
			if (!mk && int'(nbr_list[v][i]) == val) begin
				nbr_list[v][i] = nbr_list[v][cnt - 1];
				nbr_cnt[v] = cnt - 1;
				return;
			end
		end
	endfunction

	function automatic uas_pkg::rsp_t apply_request(uas_pkg::req_t r);
		uas_pkg::rsp_t o;
		int s;
		int d;
		bit e;
		bit m;
		s = int'(r.src_vertex);
		d = int'(r.dest_vertex);
		e = list_holds(1'b0, s, d);
		m = list_holds(1'b1, s, d);
		o = '0;
		o.status = uas_pkg::ST_REJECT;
		o.edge_was_present = e;
		o.mark_was_present = m;
		case (r.action)
			uas_pkg::ACT_ADD_EDGE: if (!e && s != d) begin
				if (nbr_cnt[s] >= uas_pkg::MAX_DEGREE || nbr_cnt[d] >= uas_pkg::MAX_DEGREE)
					o.status = uas_pkg::ST_FULL;
				else begin
					list_append(1'b0, s, d);
					list_append(1'b0, d, s);
					o.status = uas_pkg::ST_DONE;
				end
			end
			uas_pkg::ACT_DEL_EDGE: if (e && s != d) begin
				drop_entry(1'b0, s, d);
				drop_entry(1'b0, d, s);
				o.status = uas_pkg::ST_DONE;
			end
			uas_pkg::ACT_ADD_MARK: if (!m && e && s != d) begin
				if (mark_cnt[s] >= uas_pkg::MAX_DEGREE || mark_cnt[d] >= uas_pkg::MAX_DEGREE)
					o.status = uas_pkg::ST_FULL;
				else begin
					list_append(1'b1, s, d);
					list_append(1'b1, d, s);
					o.status = uas_pkg::ST_DONE;
				end
			end
			default: if (m && s != d) begin
				drop_entry(1'b1, s, d);
				drop_entry(1'b1, d, s);
				o.status = uas_pkg::ST_DONE;
			end
		endcase
		o.src_degree = 5'(nbr_cnt[s]);
		o.src_mark_count = 5'(mark_cnt[s]);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic [1:0] act, input int s, input int d);
		uas_pkg::req_t r;
		r.action = act;
		r.src_vertex = 8'(s);
		r.dest_vertex = 8'(d);
		while (idle_in && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_rsp.push_back(apply_request(r));
	endtask

	always @(posedge clk) begin
		uas_pkg::rsp_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = pending_rsp.pop_front();
				if (out_data.status != w.status)
					report_mismatch("status", out_data.status, w.status);
				if (out_data.edge_was_present != w.edge_was_present)
					report_mismatch("edge_was_present", out_data.edge_was_present,
						w.edge_was_present);
				if (out_data.mark_was_present != w.mark_was_present)
					report_mismatch("mark_was_present", out_data.mark_was_present,
						w.mark_was_present);
				if (out_data.src_degree != w.src_degree)
					report_mismatch("src_degree", out_data.src_degree, w.src_degree);
				if (out_data.src_mark_count != w.src_mark_count)
					report_mismatch("src_mark_count", out_data.src_mark_count,
						w.src_mark_count);
			end
		end
	end

	always @(posedge clk)
		out_stall <= hold_out || (idle_out && $urandom_range(0, 99) < 31);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("FAIL undirected_adjacency_store_unit");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(uas_pkg::ACT_ADD_EDGE, 0, 255);
		send_item(uas_pkg::ACT_ADD_EDGE, 255, 0);
		send_item(uas_pkg::ACT_ADD_EDGE, 7, 7);
		send_item(uas_pkg::ACT_ADD_MARK, 0, 255);
		send_item(uas_pkg::ACT_ADD_MARK, 255, 0);
		send_item(uas_pkg::ACT_ADD_MARK, 1, 2);
		send_item(uas_pkg::ACT_DEL_EDGE, 255, 0);
		send_item(uas_pkg::ACT_DEL_EDGE, 0, 255);
		send_item(uas_pkg::ACT_ADD_MARK, 0, 255);
		send_item(uas_pkg::ACT_DEL_MARK, 255, 0);
		send_item(uas_pkg::ACT_DEL_MARK, 0, 255);
		send_item(uas_pkg::ACT_DEL_MARK, 7, 7);
		send_item(uas_pkg::ACT_DEL_EDGE, 170, 85);
	endtask

	task automatic test_full_degree();
		for (int i = 1; i <= uas_pkg::MAX_DEGREE + 1; i++)
			send_item(uas_pkg::ACT_ADD_EDGE, 100, 100 + i);
		for (int i = 1; i <= uas_pkg::MAX_DEGREE + 1; i++)
			send_item(uas_pkg::ACT_ADD_MARK, 100 + i, 100);
		send_item(uas_pkg::ACT_DEL_EDGE, 100, 101);
		send_item(uas_pkg::ACT_ADD_EDGE, 100, 117);
		send_item(uas_pkg::ACT_ADD_MARK, 117, 100);
		send_item(uas_pkg::ACT_DEL_MARK, 100, 108);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_out <= 1'b1;
				repeat (300) @(posedge clk);
				hold_out <= 1'b0;
			end
			for (int i = 0; i < 10; i++)
				send_item(2'($urandom_range(0, 3)), $urandom_range(0, 7),
					$urandom_range(0, 7));
		join
	endtask

	task automatic test_random(input int n, input bit gaps);
		int s;
		int d;
		idle_in = gaps;
		idle_out = gaps;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				s = $urandom_range(0, 15);
				d = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0)
					s = s | 8'hF0;
				if ($urandom_range(0, 3) == 0)
					d = d | 8'hF0;
			end else begin
				s = $urandom_range(0, 255);
				d = $urandom_range(0, 255);
			end
			send_item(2'($urandom_range(0, 3)), s, d);
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		idle_in = 1'b1;
		idle_out = 1'b1;
		hold_out = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		for (int v = 0; v < uas_pkg::VERTEX_COUNT; v++) begin
			nbr_cnt[v] = 0;
			mark_cnt[v] = 0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_degree();
		test_backpressure();
		test_random(800, 1'b1);
		test_random(250, 1'b0);
		in_valid <= 1'b0;
		idle_in = 1'b1;
		idle_out = 1'b1;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("PASS undirected_adjacency_store_unit");
		else
			$display("FAIL undirected_adjacency_store_unit");
		$finish;
	end
endmodule
